// ----- sv/tld_pkg.sv -----
// Shared types, character codes and sizes for the tty line discipline.
package tld_pkg;

    // Line store size and the widths that follow from it.
    localparam int LINE_BYTES = 256;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int LEN_W      = $clog2(LINE_BYTES + 1);

    // Console characters.
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Operation carried in the input tuser.
    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PICKUP  = 2'd2
    } op_t;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_CONSOLE   = 2'd0,
        KIND_LINE      = 2'd1,
        KIND_NOT_READY = 2'd2,
        KIND_REFUSED   = 2'd3
    } kind_t;

    // Result burst handed from the editor to the output sequencer.
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       line_end;
        logic       from_mem;
    } cmd_t;

    // Line store access.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

endpackage

// ----- sv/tld_line_ram.sv -----
// Single-port line store with a registered read port.
module tld_line_ram (
    input  logic                aclk,
    input  tld_pkg::ram_req_t   req,
    output logic [7:0]          rd_data
);

    logic [7:0] mem [tld_pkg::LINE_BYTES];
    logic [7:0] rd_data_reg;

    // Write or read one entry; the read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/tld_edit.sv -----
// Line editor: owns the line length, pending flag and pickup position.
module tld_edit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [1:0]          op,
    input  logic [7:0]          data_byte,
    input  logic                stop_after,
    output tld_pkg::cmd_t       cmd,
    output tld_pkg::ram_req_t   req
);

    logic [tld_pkg::LEN_W-1:0] len_reg, len_next;
    logic [tld_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic                      pending_reg, pending_next;
    logic [tld_pkg::LEN_W-1:0] pos_inc;
    logic                      is_eol;
    logic                      is_erase;
    logic                      final_byte;

    assign pos_inc    = pos_reg + tld_pkg::LEN_W'(1);
    assign is_eol     = (data_byte == tld_pkg::CH_CR) || (data_byte == tld_pkg::CH_LF);
    assign is_erase   = (data_byte == tld_pkg::CH_BS) || (data_byte == tld_pkg::CH_DEL);
    assign final_byte = stop_after || (pos_inc >= len_reg);

    // Decode the item: state update, store access and result burst.
    always_comb begin
        len_next     = len_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        req          = '0;
        cmd          = '0;
        cmd.kind     = tld_pkg::KIND_CONSOLE;
        case (tld_pkg::op_t'(op))
            tld_pkg::OP_RECEIVE: begin
                if (pending_reg) begin
                    cmd.valid = 1'b1;
                    cmd.kind  = tld_pkg::KIND_REFUSED;
                    cmd.count = 2'd1;
                end else if (is_eol) begin
                    if (len_reg < tld_pkg::LEN_W'(tld_pkg::LINE_BYTES)) begin
                        req.wr_en = 1'b1;
                        req.addr  = len_reg[tld_pkg::ADDR_W-1:0];
                        req.wdata = tld_pkg::CH_CR;
                        len_next  = len_reg + tld_pkg::LEN_W'(1);
                    end
                    pending_next = 1'b1;
                    pos_next     = '0;
                    cmd.valid    = 1'b1;
                    cmd.count    = 2'd2;
                    cmd.b0       = tld_pkg::CH_CR;
                    cmd.b1       = tld_pkg::CH_LF;
                end else if (is_erase) begin
                    if (len_reg != '0) begin
                        len_next  = len_reg - tld_pkg::LEN_W'(1);
                        cmd.valid = 1'b1;
                        cmd.count = 2'd3;
                        cmd.b0    = tld_pkg::CH_BS;
                        cmd.b1    = tld_pkg::CH_SP;
                        cmd.b2    = tld_pkg::CH_BS;
                    end
                end else if (len_reg < tld_pkg::LEN_W'(tld_pkg::LINE_BYTES - 1)) begin
                    req.wr_en = 1'b1;
                    req.addr  = len_reg[tld_pkg::ADDR_W-1:0];
                    req.wdata = data_byte;
                    len_next  = len_reg + tld_pkg::LEN_W'(1);
                    cmd.valid = 1'b1;
                    cmd.count = 2'd1;
                    cmd.b0    = data_byte;
                end
            end
            tld_pkg::OP_WRITE: begin
                cmd.valid = 1'b1;
                if (is_eol) begin
                    cmd.count    = 2'd2;
                    cmd.b0       = tld_pkg::CH_CR;
                    cmd.b1       = tld_pkg::CH_LF;
                    cmd.line_end = 1'b1;
                end else begin
                    cmd.count = 2'd1;
                    cmd.b0    = data_byte;
                end
            end
            tld_pkg::OP_PICKUP: begin
                cmd.valid = 1'b1;
                cmd.count = 2'd1;
                if (!pending_reg) begin
                    cmd.kind = tld_pkg::KIND_NOT_READY;
                end else begin
                    req.rd_en    = 1'b1;
                    req.addr     = pos_reg[tld_pkg::ADDR_W-1:0];
                    cmd.kind     = tld_pkg::KIND_LINE;
                    cmd.from_mem = 1'b1;
                    cmd.line_end = final_byte;
                    if (final_byte) begin
                        len_next     = '0;
                        pending_next = 1'b0;
                        pos_next     = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            default: begin
                // Unused operation: no result, no change.
            end
        endcase
        if (!accept) begin
            len_next     = len_reg;
            pos_next     = pos_reg;
            pending_next = pending_reg;
            req.wr_en    = 1'b0;
            req.rd_en    = 1'b0;
            cmd.valid    = 1'b0;
        end
    end

    // Line state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            pos_reg     <= '0;
            pending_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- sv/tld_echo.sv -----
// Output sequencer: holds one result burst and sends it one item per cycle while m_tready is high.
module tld_echo (
    input  logic            aclk,
    input  logic            aresetn,
    input  tld_pkg::cmd_t   cmd,
    input  logic [7:0]      rd_data,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    logic          valid_reg, valid_next;
    tld_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0]    step_reg, step_next;
    logic          is_last;
    logic          fire;

    assign is_last  = (step_reg == (cmd_reg.count - 2'd1));
    assign fire     = valid_reg && m_tready;
    assign free     = !valid_reg || (fire && is_last);
    assign m_tvalid = valid_reg;
    assign m_tlast  = is_last;
    assign m_tuser  = {cmd_reg.line_end, cmd_reg.kind};

    // Pick the byte of the current step.
    always_comb begin
        case (step_reg)
            2'd0:    m_tdata = cmd_reg.from_mem ? rd_data : cmd_reg.b0;
            2'd1:    m_tdata = cmd_reg.b1;
            default: m_tdata = cmd_reg.b2;
        endcase
    end

    // Load a new burst, or step through the current one.
    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        if (cmd.valid) begin
            valid_next = 1'b1;
            cmd_next   = cmd;
            step_next  = 2'd0;
        end else if (fire) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

// ----- sv/tty_line_discipline.sv -----
// Top level of the tty line discipline.
//
// Input channel (s_): one item per operation. tuser carries the operation
// (receive console byte, write cooked byte, pick up line byte), tdata the
// byte and tlast the pickup stop flag.
// Result channel (m_): tdata is the byte, tuser the result kind and the line
// end flag, tlast marks the final result caused by an input item.
// An item produces zero to three result items. The first result appears in the
// cycle after the input item is accepted; results then follow one per cycle
// while m_tready is high. The output sequencer holds one burst; the line
// store is read in the cycle of acceptance and its registered data feeds the
// pickup result. The next input item is accepted in the same cycle as the
// final result of the previous one is taken. When the receiver stalls, the
// held burst waits and s_tready stays low. Reset clears the line length,
// pending flag and pickup position; the line store needs no clearing.
module tty_line_discipline (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic [1:0] s_tuser,    // [1:0] operation
    input  logic       s_tlast,    // stop_after
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [2:0] m_tuser,    // [1:0] kind, [2] line_end
    output logic       m_tlast     // last
);

    tld_pkg::cmd_t     cmd;
    tld_pkg::ram_req_t req;
    logic [7:0]        rd_data;
    logic              free;
    logic              accept;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    // Line editing and state update.
    tld_edit u_edit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_tuser),
        .data_byte  (s_tdata),
        .stop_after (s_tlast),
        .cmd        (cmd),
        .req        (req)
    );

    // Line store.
    tld_line_ram u_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Result sequencing.
    tld_echo u_echo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_data  (rd_data),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sv/tld_checker.sv -----
// Port-level checks for the tty line discipline, bound to the top level.
module tld_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The results of one item come without gaps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a result burst");

    // Refused and not ready results are single, zero and not line ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == tld_pkg::KIND_REFUSED ||
                     m_tuser[1:0] == tld_pkg::KIND_NOT_READY)
        |-> m_tlast && (m_tdata == 8'd0) && !m_tuser[2])
        else $error("bad status result");

    // A line byte is always the only result of its pickup.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == tld_pkg::KIND_LINE) |-> m_tlast)
        else $error("line byte not final");

    // Reset empties the result channel.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tty_line_discipline tld_checker u_tld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
